>>> hw/rtl/hbs_pkg.sv
// Shared constants, types and helpers for the heightmap bilinear sampler.
package hbs_pkg;

    localparam int MAX_GRID   = 256;
    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int CELL_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int W2G_W      = 16;
    localparam int W2G_FRAC   = 12;
    localparam int WORLD_W    = 24;
    localparam int PROD_W     = WORLD_W + W2G_W;
    localparam int GFULL_W    = PROD_W - W2G_FRAC;
    localparam int FRAC_W     = 8;
    localparam int GRID_W     = IDX_W + FRAC_W;
    localparam int H_W        = 16;
    localparam int BT_W       = H_W + FRAC_W;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 9'd256;
    localparam logic [W2G_W-1:0]  W2G_RST       = 16'd4096;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_TO_GRID = 1'b1;

    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        x;
        logic [IDX_W-1:0]        z;
        logic signed [H_W-1:0]   data;
    } hbs_wr_t;

    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        ix;
        logic [IDX_W-1:0]        iz;
    } hbs_rd_t;

    typedef struct packed {
        logic signed [H_W-1:0]   h00;
        logic signed [H_W-1:0]   h10;
        logic signed [H_W-1:0]   h01;
        logic signed [H_W-1:0]   h11;
    } hbs_quad_t;

    typedef struct packed {
        logic [FRAC_W-1:0]       fx;
        logic [FRAC_W-1:0]       fz;
        logic                    at_edge;
    } hbs_frac_t;

    // Clamp limit in grid units: (effective size - 1) << FRAC_W
    function automatic logic [GRID_W-1:0] eff_lim(input logic [SIZE_W-1:0] gs);
        int s;
        s = int'(gs);
        if (s > MAX_GRID)
        begin
            s = MAX_GRID;
        end
        if (s < 1)
        begin
            s = 1;
        end
        return GRID_W'((s - 1) << FRAC_W);
    endfunction

endpackage

>>> hw/rtl/hbs_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module hbs_ram #(
    parameter int AW = 14,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hbs_grid.sv
// Height grid split into four parity banks; one sample write and one four-neighbor read per cycle.
module hbs_grid (
    input  logic               clk,
    input  hbs_pkg::hbs_wr_t   wr,
    input  hbs_pkg::hbs_rd_t   rd,
    output hbs_pkg::hbs_quad_t quad
);

    logic [hbs_pkg::H_W-1:0] rdata [4];
    logic                    ix0_reg;
    logic                    iz0_reg;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PZ = 1'(b / 2);

        logic                         bank_we;
        logic [hbs_pkg::BANK_AW-1:0]  bank_waddr;
        logic [hbs_pkg::BANK_AW-1:0]  bank_raddr;
        logic [hbs_pkg::IDX_W-1:0]    col;
        logic [hbs_pkg::IDX_W-1:0]    row;

        assign bank_we    = wr.en && (wr.x[0] == PX) && (wr.z[0] == PZ);
        assign bank_waddr = {wr.z[hbs_pkg::IDX_W-1:1], wr.x[hbs_pkg::IDX_W-1:1]};
        assign col        = (rd.ix[0] == PX) ? rd.ix : rd.ix + hbs_pkg::IDX_W'(1);
        assign row        = (rd.iz[0] == PZ) ? rd.iz : rd.iz + hbs_pkg::IDX_W'(1);
        assign bank_raddr = {row[hbs_pkg::IDX_W-1:1], col[hbs_pkg::IDX_W-1:1]};

        hbs_ram #(
            .AW(hbs_pkg::BANK_AW),
            .DW(hbs_pkg::H_W)
        ) u_ram (
            .clk  (clk),
            .we   (bank_we),
            .waddr(bank_waddr),
            .wdata(wr.data),
            .re   (rd.en),
            .raddr(bank_raddr),
            .rdata(rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            ix0_reg <= rd.ix[0];
            iz0_reg <= rd.iz[0];
        end
    end

    // bank index is {row parity, column parity}
    assign quad.h00 = rdata[{iz0_reg, ix0_reg}];
    assign quad.h10 = rdata[{iz0_reg, ~ix0_reg}];
    assign quad.h01 = rdata[{~iz0_reg, ix0_reg}];
    assign quad.h11 = rdata[{~iz0_reg, ~ix0_reg}];

endmodule

>>> hw/rtl/hbs_lerp.sv
// Two-stage bilinear blend: x lerp on both rows, then z lerp with rounding.
module hbs_lerp (
    input  logic                                clk,
    input  logic                                en_x,
    input  logic                                en_z,
    input  hbs_pkg::hbs_quad_t                  quad,
    input  hbs_pkg::hbs_frac_t                  frac,
    output logic signed [hbs_pkg::OUT_W-1:0]    result
);

    localparam int PX_W = hbs_pkg::H_W + hbs_pkg::FRAC_W + 2;
    localparam int PZ_W = hbs_pkg::BT_W + hbs_pkg::FRAC_W + 2;

    logic signed [hbs_pkg::H_W:0]         d_bot;
    logic signed [hbs_pkg::H_W:0]         d_top;
    logic signed [PX_W-1:0]               p_bot;
    logic signed [PX_W-1:0]               p_top;
    logic signed [PX_W-1:0]               s_bot;
    logic signed [PX_W-1:0]               s_top;
    logic signed [hbs_pkg::BT_W-1:0]      h00_q8;
    logic signed [hbs_pkg::BT_W-1:0]      bot_next;
    logic signed [hbs_pkg::BT_W-1:0]      top_next;
    logic signed [hbs_pkg::BT_W-1:0]      bot_reg;
    logic signed [hbs_pkg::BT_W-1:0]      top_reg;
    logic [hbs_pkg::FRAC_W-1:0]           fz_reg;
    logic signed [hbs_pkg::BT_W:0]        d_z;
    logic signed [PZ_W-1:0]               p_z;
    logic signed [PZ_W-1:0]               fin;
    logic signed [PZ_W-1:0]               rnd;
    logic signed [hbs_pkg::OUT_W-1:0]     result_next;
    logic signed [hbs_pkg::OUT_W-1:0]     result_reg;

    always_comb
    begin
        d_bot  = {quad.h10[hbs_pkg::H_W-1], quad.h10} - {quad.h00[hbs_pkg::H_W-1], quad.h00};
        d_top  = {quad.h11[hbs_pkg::H_W-1], quad.h11} - {quad.h01[hbs_pkg::H_W-1], quad.h01};
        p_bot  = d_bot * $signed({1'b0, frac.fx});
        p_top  = d_top * $signed({1'b0, frac.fx});
        s_bot  = {{2{quad.h00[hbs_pkg::H_W-1]}}, quad.h00, {hbs_pkg::FRAC_W{1'b0}}} + p_bot;
        s_top  = {{2{quad.h01[hbs_pkg::H_W-1]}}, quad.h01, {hbs_pkg::FRAC_W{1'b0}}} + p_top;
        h00_q8 = {quad.h00, {hbs_pkg::FRAC_W{1'b0}}};
        // edge: corner sample, top == bottom makes the z blend a pass-through
        bot_next = frac.at_edge ? h00_q8 : s_bot[hbs_pkg::BT_W-1:0];
        top_next = frac.at_edge ? h00_q8 : s_top[hbs_pkg::BT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_x)
        begin
            bot_reg <= bot_next;
            top_reg <= top_next;
            fz_reg  <= frac.fz;
        end
    end

    always_comb
    begin
        d_z = {top_reg[hbs_pkg::BT_W-1], top_reg} - {bot_reg[hbs_pkg::BT_W-1], bot_reg};
        p_z = d_z * $signed({1'b0, fz_reg});
        fin = {{2{bot_reg[hbs_pkg::BT_W-1]}}, bot_reg, {hbs_pkg::FRAC_W{1'b0}}} + p_z;
        rnd = fin + PZ_W'(128);
        result_next = rnd[hbs_pkg::FRAC_W +: hbs_pkg::OUT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en_z)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> hw/rtl/heightmap_bilinear_sampler_top.sv
// Top level of the heightmap bilinear sampler: config, scaling, address stage and pipeline control.
// A query passes the input, grid read and x-blend registers, then the result register.
// One item per cycle unless out_ready stalls; writes and queries mix freely, writes give no result.
// The four grid neighbors come from four parity banks read in the same cycle.
// Reset: grid_size = 256, world_to_grid = 4096, pipeline empty; the grid is not cleared.
module heightmap_bilinear_sampler_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [hbs_pkg::CELL_W-1:0]            cell_x,
    input  logic [hbs_pkg::CELL_W-1:0]            cell_z,
    input  logic signed [hbs_pkg::H_W-1:0]        height_in,
    input  logic [hbs_pkg::WORLD_W-1:0]           world_x,
    input  logic [hbs_pkg::WORLD_W-1:0]           world_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [hbs_pkg::OUT_W-1:0]      height_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [hbs_pkg::GRID_W-1:0]          lim_reg;
    logic [hbs_pkg::W2G_W-1:0]           w2g_reg;

    logic                                s1_v_reg;
    logic                                s2_v_reg;
    logic                                s3_v_reg;
    logic                                out_v_reg;
    logic                                en1;
    logic                                en2;
    logic                                en3;
    logic                                en_out;

    logic                                s1_cmd_reg;
    logic [hbs_pkg::CELL_W-1:0]          s1_cell_x_reg;
    logic [hbs_pkg::CELL_W-1:0]          s1_cell_z_reg;
    logic signed [hbs_pkg::H_W-1:0]      s1_height_reg;
    logic [hbs_pkg::PROD_W-1:0]          s1_prod_x_reg;
    logic [hbs_pkg::PROD_W-1:0]          s1_prod_z_reg;
    logic [hbs_pkg::PROD_W-1:0]          prod_x_next;
    logic [hbs_pkg::PROD_W-1:0]          prod_z_next;

    logic [hbs_pkg::GFULL_W-1:0]         gx_full;
    logic [hbs_pkg::GFULL_W-1:0]         gz_full;
    logic [hbs_pkg::GRID_W-1:0]          gx;
    logic [hbs_pkg::GRID_W-1:0]          gz;
    logic [hbs_pkg::IDX_W-1:0]           last_idx;
    logic                                cell_ok;

    hbs_pkg::hbs_wr_t                    wr;
    hbs_pkg::hbs_rd_t                    rd;
    hbs_pkg::hbs_quad_t                  quad;
    hbs_pkg::hbs_frac_t                  frac_next;
    hbs_pkg::hbs_frac_t                  s2_frac_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= hbs_pkg::eff_lim(hbs_pkg::GRID_SIZE_RST);
            w2g_reg <= hbs_pkg::W2G_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hbs_pkg::REG_GRID_SIZE:
                begin
                    lim_reg <= hbs_pkg::eff_lim(cfg_data[hbs_pkg::SIZE_W-1:0]);
                end
                hbs_pkg::REG_WORLD_TO_GRID:
                begin
                    w2g_reg <= cfg_data[hbs_pkg::W2G_W-1:0];
                end
            endcase
        end
    end

    // each stage moves when it is empty or the next one moves
    assign en_out    = !out_v_reg || out_ready;
    assign en3       = !s3_v_reg || en_out;
    assign en2       = !s2_v_reg || en3;
    assign en1       = !s1_v_reg || en2;
    assign in_ready  = en1;
    assign out_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= in_valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg && (s1_cmd_reg == hbs_pkg::CMD_QUERY);
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    assign prod_x_next = hbs_pkg::PROD_W'(world_x) * hbs_pkg::PROD_W'(w2g_reg);
    assign prod_z_next = hbs_pkg::PROD_W'(world_z) * hbs_pkg::PROD_W'(w2g_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cmd_reg    <= cmd;
            s1_cell_x_reg <= cell_x;
            s1_cell_z_reg <= cell_z;
            s1_height_reg <= height_in;
            s1_prod_x_reg <= prod_x_next;
            s1_prod_z_reg <= prod_z_next;
        end
    end

    always_comb
    begin
        gx_full  = s1_prod_x_reg[hbs_pkg::PROD_W-1:hbs_pkg::W2G_FRAC];
        gz_full  = s1_prod_z_reg[hbs_pkg::PROD_W-1:hbs_pkg::W2G_FRAC];
        gx       = (gx_full > hbs_pkg::GFULL_W'(lim_reg)) ? lim_reg
                                                          : gx_full[hbs_pkg::GRID_W-1:0];
        gz       = (gz_full > hbs_pkg::GFULL_W'(lim_reg)) ? lim_reg
                                                          : gz_full[hbs_pkg::GRID_W-1:0];
        last_idx = lim_reg[hbs_pkg::GRID_W-1:hbs_pkg::FRAC_W];

        rd.en = en2 && s1_v_reg && (s1_cmd_reg == hbs_pkg::CMD_QUERY);
        rd.ix = gx[hbs_pkg::GRID_W-1:hbs_pkg::FRAC_W];
        rd.iz = gz[hbs_pkg::GRID_W-1:hbs_pkg::FRAC_W];

        frac_next.fx      = gx[hbs_pkg::FRAC_W-1:0];
        frac_next.fz      = gz[hbs_pkg::FRAC_W-1:0];
        frac_next.at_edge = (rd.ix == last_idx) || (rd.iz == last_idx);

        cell_ok = (32'(s1_cell_x_reg) < 32'(hbs_pkg::MAX_GRID))
               && (32'(s1_cell_z_reg) < 32'(hbs_pkg::MAX_GRID));
        wr.en   = en2 && s1_v_reg && (s1_cmd_reg == hbs_pkg::CMD_WRITE) && cell_ok;
        wr.x    = hbs_pkg::IDX_W'(s1_cell_x_reg);
        wr.z    = hbs_pkg::IDX_W'(s1_cell_z_reg);
        wr.data = s1_height_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_frac_reg <= frac_next;
        end
    end

    hbs_grid u_grid (
        .clk (clk),
        .wr  (wr),
        .rd  (rd),
        .quad(quad)
    );

    hbs_lerp u_lerp (
        .clk   (clk),
        .en_x  (en3),
        .en_z  (en_out),
        .quad  (quad),
        .frac  (s2_frac_reg),
        .result(height_out)
    );

endmodule

>>> hw/rtl/hbs_checker.sv
// Port-level assertions for the heightmap bilinear sampler, bound to the top level.
module hbs_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [hbs_pkg::OUT_W-1:0]      height_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(height_out))
        else $error("result item changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_ready && !out_valid)
        else $error("pipeline not empty after reset");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled output");

    a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .height_out(height_out)
);
